/* src/simplex_noise_3d_core_macros.svh */
// assertion macros for the simplex noise core
`ifndef SIMPLEX_NOISE_3D_CORE_MACROS_SVH
`define SIMPLEX_NOISE_3D_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SNZ_ASSERT_NOW(name, pre, post) \
name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
else $error("snz check failed");
`define SNZ_ASSERT_NEXT(name, pre, post) \
name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
else $error("snz check failed");
`else
`define SNZ_ASSERT_NOW(name, pre, post)
`define SNZ_ASSERT_NEXT(name, pre, post)
`endif
`endif

/* src/snz_pkg.sv */
// constants, permutation table and gradient helper for the simplex noise core
`default_nettype none
package snz_pkg;
   localparam int IFRAC = 24;
   localparam int OFF_W = 27;
   localparam int D_W = 28;
   localparam int DP_W = D_W + 1;
   localparam int RR_W = 58;
   localparam logic [OFF_W-1:0] G3_Q = 27'd2796203;
   localparam logic [OFF_W-1:0] G3X2_Q = 27'd5592405;
   localparam logic [OFF_W-1:0] G3X3_Q = 27'd8388608;
   localparam logic [OFF_W-1:0] ONE_Q = 27'd16777216;
   localparam logic signed [RR_W-1:0] FALL_Q48 = 58'sd10066330 <<< IFRAC;

   localparam logic [7:0] PERM [256] = '{
      8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,
      8'd194,8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
      8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,
      8'd0,8'd26,8'd197,8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
      8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,
      8'd171,8'd168,8'd68,8'd175,8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
      8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,
      8'd220,8'd105,8'd92,8'd41,8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
      8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,
      8'd208,8'd89,8'd18,8'd169,8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
      8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,
      8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
      8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,
      8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
      8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,
      8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
      8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,
      8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
      8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,8'd184,8'd84,8'd204,8'd176,
      8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
      8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,8'd128,8'd195,8'd78,8'd66,
      8'd215,8'd61,8'd156,8'd180};

   // dot product of the edge gradient selected by g with an offset, an unused g gives zero
   function automatic logic signed [DP_W-1:0] grad_dot(input logic [3:0] g,
         input logic signed [D_W-1:0] dx, input logic signed [D_W-1:0] dy,
         input logic signed [D_W-1:0] dz);
      logic signed [DP_W-1:0] ex, ey, ez, res;
      ex = DP_W'(dx);
      ey = DP_W'(dy);
      ez = DP_W'(dz);
      case (g)
         4'd0: res = ex + ey;
         4'd1: res = ey - ex;
         4'd2: res = ex - ey;
         4'd3: res = -ex - ey;
         4'd4: res = ex + ez;
         4'd5: res = ez - ex;
         4'd6: res = ex - ez;
         4'd7: res = -ex - ez;
         4'd8: res = ey + ez;
         4'd9: res = ez - ey;
         4'd10: res = ey - ez;
         4'd11: res = -ey - ez;
         default: res = '0;
      endcase
      return res;
   endfunction
endpackage
`default_nettype wire

/* src/snz_div3.sv */
// signed floor division by three through a reciprocal multiply
`default_nettype none
module snz_div3 #(
   parameter int W = 21
) (
   input  logic signed [W-1:0] num,
   output logic signed [W-1:0] quo,
   output logic [1:0]          rem
);
   localparam int S = W + 3;
   localparam int PW = 2 * W + 3;
   localparam logic [W+1:0] M = (W+2)'(((64'd1 << S) + 64'd2) / 64'd3);
   localparam logic [W:0] BIAS = (W+1)'(3) << (W - 1);

   logic [W:0]    u;
   logic [PW-1:0] prod;
   logic [W-1:0]  uq;
   logic [W:0]    back;

   // bias to a positive value so the unsigned reciprocal is exact
   assign u = (W+1)'(num) + BIAS;
   assign prod = PW'(u) * PW'(M);
   assign uq = prod[PW-1:S];
   assign quo = signed'(uq ^ (W'(1) << (W - 1)));
   assign back = u - (W+1)'(uq) * (W+1)'(3);
   assign rem = back[1:0];
endmodule
`default_nettype wire

/* src/simplex_noise_3d_core.sv */
// top level: pipelined fixed-point 3d simplex noise
// an accepted item passes through 12 register stages before rsp_tvalid rises
// throughput: one item per cycle while the output is not stalled, the 12 register stages never recirculate
// a stalled result freezes the whole pipeline, nothing is dropped or repeated
// reset clears the stage valid bits only, data registers are left as they are
`default_nettype none
`include "simplex_noise_3d_core_macros.svh"
module simplex_noise_3d_core #(
   parameter int COORD_FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // x_coord, y_coord, z_coord
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // noise_value
);
   import snz_pkg::*;

   localparam int QW = 35 - COORD_FRAC_BITS;  // skewed cell coordinate
   localparam int SW = QW + 2;                // sum of three cell indices
   localparam int SHL = IFRAC - COORD_FRAC_BITS;
   localparam int NST = 11;                   // stages ahead of the output register

   // global advance: a stage moves when the output slot is free or drains
   logic en;
   logic [NST:1] vld_ff;
   logic rsp_tvalid_ff;
   logic signed [15:0] noise_ff, noise_in;

   assign en = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata = noise_ff;

   // stage 1: skew sums and floor shift
   logic signed [31:0] crd [3];
   logic signed [34:0] ssum [3];
   logic signed [QW-1:0] q_ff [3], q_in [3];
   logic signed [31:0] c1_ff [3];
   // stage 2: cell index through the divide by three
   logic signed [QW-1:0] idx_in [3], idx2_ff [3];
   logic signed [31:0] c2_ff [3];
   // stage 3: unskew quotient and remainder
   logic signed [SW-1:0] cs;
   logic signed [SW-1:0] a_in, a3_ff;
   logic [1:0] r_in, r3_ff;
   logic signed [QW-1:0] idx3_ff [3];
   logic signed [31:0] c3_ff [3];
   // stage 4: first corner offsets in q.24, wrapped cell indices
   logic [OFF_W-1:0] tv;
   logic signed [OFF_W-1:0] off_in [3], off4_ff [3];
   logic [7:0] cell4_ff [3];
   // stage 5: corner offsets, first hash lookup
   logic [2:0] st1, st2;
   logic [2:0] inc [4];
   logic signed [D_W-1:0] d_in [4][3], d5_ff [4][3], d6_ff [4][3];
   logic signed [D_W-1:0] d7_ff [4][3], d8_ff [4][3];
   logic [7:0] hi_in [4], hj_in [4], h_in [4];
   logic [7:0] hi5_ff [4], hj5_ff [4], h5_ff [4];
   // stage 6: squared distance, second lookup
   logic [7:0] hi6_ff [4], h6_ff [4], h6_in [4];
   logic signed [RR_W-1:0] rr_in [4], rr6_ff [4];
   // stage 7: falloff, third lookup
   logic signed [RR_W-1:0] t48 [4];
   logic signed [RR_W-1:0] t48r [4];
   logic [23:0] t24_in [4], t24_7_ff [4];
   logic live_in [4], live7_ff [4], live8_ff [4], live9_ff [4];
   logic [7:0] h7_in [4], h7_ff [4];
   // stage 8: t squared, gradient index
   logic [47:0] sq1 [4], sq2 [4];
   logic [23:0] t2_in [4], t2_8_ff [4], t4_in [4], t4_9_ff [4];
   logic [15:0] m171 [4];
   logic [7:0] g8b [4];
   logic [3:0] g_in [4], g8_ff [4];
   // stage 9: t to the fourth, gradient dot product
   logic signed [DP_W-1:0] dp_in [4], dp9_ff [4];
   // stage 10: contributions
   logic signed [53:0] pr_in [4], pr10_ff [4];
   // stage 11: sum
   logic signed [55:0] sum_in, sum11_ff;
   logic signed [55:0] sumr;
   logic signed [27:0] vsc;

   // ---------------- stage 1 ----------------
   always_comb begin
      crd[0] = signed'(req_tdata[31:0]);
      crd[1] = signed'(req_tdata[63:32]);
      crd[2] = signed'(req_tdata[95:64]);
      // 4 times own axis plus the other two, then floor shift
      for (int a = 0; a < 3; a++) begin
         ssum[a] = (35'(crd[a]) <<< 2) + 35'(crd[(a+1)%3]) + 35'(crd[(a+2)%3]);
         q_in[a] = ssum[a][34:COORD_FRAC_BITS];
      end
   end

   // ---------------- stage 2 ----------------
   for (genvar a = 0; a < 3; a++) begin : g_cell
      logic [1:0] unused_rem;
      snz_div3 #(.W(QW)) u_div (.num(q_ff[a]), .quo(idx_in[a]), .rem(unused_rem));
   end

   // ---------------- stage 3 ----------------
   assign cs = SW'(idx2_ff[0]) + SW'(idx2_ff[1]) + SW'(idx2_ff[2]);
   snz_div3 #(.W(SW)) u_unskew (.num(cs), .quo(a_in), .rem(r_in));

   // ---------------- stage 4 ----------------
   always_comb begin
      // t = (i+j+k)/6 in q.24: quotient by three times 2^23 plus a remainder term
      case (r3_ff)
         2'd1: tv = G3_Q;
         2'd2: tv = G3X2_Q;
         default: tv = '0;
      endcase
      tv = tv + {a3_ff[3:0], 23'b0};
      // only the low bits matter, the offsets are bounded
      for (int a = 0; a < 3; a++) begin
         off_in[a] = signed'((OFF_W'(c3_ff[a]) << SHL) - {idx3_ff[a][2:0], 24'b0} + tv);
      end
   end

   // ---------------- stage 5 ----------------
   always_comb begin
      // tetrahedron choice, bits are {i,j,k} steps of corners 1 and 2
      if (off4_ff[0] >= off4_ff[1]) begin
         if (off4_ff[1] >= off4_ff[2]) begin
            st1 = 3'b100; st2 = 3'b110;
         end else if (off4_ff[0] >= off4_ff[2]) begin
            st1 = 3'b100; st2 = 3'b101;
         end else begin
            st1 = 3'b001; st2 = 3'b101;
         end
      end else begin
         if (off4_ff[1] < off4_ff[2]) begin
            st1 = 3'b001; st2 = 3'b011;
         end else if (off4_ff[0] < off4_ff[2]) begin
            st1 = 3'b010; st2 = 3'b011;
         end else begin
            st1 = 3'b010; st2 = 3'b110;
         end
      end
      inc[0] = 3'b000;
      inc[1] = st1;
      inc[2] = st2;
      inc[3] = 3'b111;
      for (int c = 0; c < 4; c++) begin
         for (int a = 0; a < 3; a++) begin
            d_in[c][a] = D_W'(off4_ff[a]);
            if (inc[c][2-a])
               d_in[c][a] = d_in[c][a] - signed'({1'b0, ONE_Q});
         end
         for (int a = 0; a < 3; a++) begin
            case (c)
               1: d_in[c][a] = d_in[c][a] + signed'({1'b0, G3_Q});
               2: d_in[c][a] = d_in[c][a] + signed'({1'b0, G3X2_Q});
               3: d_in[c][a] = d_in[c][a] + signed'({1'b0, G3X3_Q});
               default: d_in[c][a] = d_in[c][a];
            endcase
         end
         hi_in[c] = cell4_ff[0] + 8'(inc[c][2]);
         hj_in[c] = cell4_ff[1] + 8'(inc[c][1]);
         h_in[c] = PERM[cell4_ff[2] + 8'(inc[c][0])];
      end
   end

   // ---------------- stages 6 to 11 ----------------
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         // stage 6: full-width squares, operands widened first
         rr_in[c] = RR_W'(d5_ff[c][0]) * RR_W'(d5_ff[c][0])
                    + RR_W'(d5_ff[c][1]) * RR_W'(d5_ff[c][1])
                    + RR_W'(d5_ff[c][2]) * RR_W'(d5_ff[c][2]);
         h6_in[c] = PERM[hj5_ff[c] + h5_ff[c]];
         // stage 7: zero contribution outside the falloff radius
         t48[c] = FALL_Q48 - rr6_ff[c];
         live_in[c] = !t48[c][RR_W-1];
         t48r[c] = t48[c] + (RR_W'(1) <<< (IFRAC - 1));
         t24_in[c] = t48r[c][47:24];
         h7_in[c] = PERM[hi6_ff[c] + h6_ff[c]];
         // stage 8: round half up, gradient index as hash mod 12
         sq1[c] = 48'(t24_7_ff[c]) * 48'(t24_7_ff[c]) + (48'(1) << (IFRAC - 1));
         t2_in[c] = sq1[c][47:24];
         m171[c] = 16'(h7_ff[c]) * 16'd171;
         g8b[c] = h7_ff[c] - 8'(m171[c][15:11]) * 8'd12;
         g_in[c] = g8b[c][3:0];
         // stage 9
         sq2[c] = 48'(t2_8_ff[c]) * 48'(t2_8_ff[c]) + (48'(1) << (IFRAC - 1));
         t4_in[c] = sq2[c][47:24];
         dp_in[c] = grad_dot(g8_ff[c], d8_ff[c][0], d8_ff[c][1], d8_ff[c][2]);
         // stage 10
         pr_in[c] = live9_ff[c] ? 54'(signed'({1'b0, t4_9_ff[c]})) * 54'(dp9_ff[c]) : '0;
      end
      // stage 11
      sum_in = 56'(pr10_ff[0]) + 56'(pr10_ff[1]) + 56'(pr10_ff[2]) + 56'(pr10_ff[3]);
      // output: scale by 32 with rounding, saturate to q1.15
      sumr = sum11_ff + (56'sd1 <<< 27);
      vsc = signed'(sumr[55:28]);
      if (vsc > 28'sd32767)
         noise_in = 16'sh7fff;
      else if (vsc < -28'sd32768)
         noise_in = -16'sh8000;
      else
         noise_in = sumr[43:28];
   end

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= {vld_ff[NST-1:1], req_tvalid};
         rsp_tvalid_ff <= vld_ff[NST];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q_ff <= q_in;
         c1_ff <= crd;
         idx2_ff <= idx_in;
         c2_ff <= c1_ff;
         idx3_ff <= idx2_ff;
         c3_ff <= c2_ff;
         a3_ff <= a_in;
         r3_ff <= r_in;
         off4_ff <= off_in;
         for (int a = 0; a < 3; a++)
            cell4_ff[a] <= idx3_ff[a][7:0];
         d5_ff <= d_in;
         hi5_ff <= hi_in;
         hj5_ff <= hj_in;
         h5_ff <= h_in;
         d6_ff <= d5_ff;
         hi6_ff <= hi5_ff;
         h6_ff <= h6_in;
         rr6_ff <= rr_in;
         d7_ff <= d6_ff;
         t24_7_ff <= t24_in;
         live7_ff <= live_in;
         h7_ff <= h7_in;
         d8_ff <= d7_ff;
         t2_8_ff <= t2_in;
         live8_ff <= live7_ff;
         g8_ff <= g_in;
         t4_9_ff <= t4_in;
         live9_ff <= live8_ff;
         dp9_ff <= dp_in;
         pr10_ff <= pr_in;
         sum11_ff <= sum_in;
         noise_ff <= noise_in;
      end
   end

   // a waiting result holds the input side
   `SNZ_ASSERT_NOW(a_stall_blocks_input, rsp_tvalid && !rsp_tready, !req_tready)
   // an empty output slot never blocks input
   `SNZ_ASSERT_NOW(a_free_accepts, !rsp_tvalid, req_tready)
   // an accepted item lands in the first stage
   `SNZ_ASSERT_NEXT(a_item_enters, req_tvalid && req_tready, vld_ff[1])
endmodule
`default_nettype wire
